// ===== rtl/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg: shared types and constants of the biquad cascade
// Sample, state, coefficient and accumulator widths, register indexes,
// reset values and the beat handed from one stage cell to the next.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int NUM_STAGES = 4;

  localparam int SAMPLE_W   = 16;                  // Q15 port samples
  localparam int STATE_W    = 24;                  // Q8.15 stage values
  localparam int COEF_W     = 24;                  // Q2.22 coefficients
  localparam int PROD_W     = COEF_W + STATE_W;    // exact product
  localparam int ACC_W      = PROD_W + 3;          // sum of five products
  localparam int FRAC_SHIFT = 22;                  // coefficient fraction bits
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_COEF_B0 = 3'd1,
    REG_COEF_B1 = 3'd2,
    REG_COEF_B2 = 3'd3,
    REG_COEF_A1 = 3'd4,
    REG_COEF_A2 = 3'd5
  } reg_idx_e;

  localparam logic signed [COEF_W-1:0] COEF_B0_RST = 24'sd4194304;  // 1.0
  localparam logic signed [COEF_W-1:0] COEF_RST    = 24'sd0;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic                      valid;
    logic signed [STATE_W-1:0] data;
  } stage_beat_t;

endpackage

// ===== rtl/biquad_cascade_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_filter: cascade of direct-form-I biquads on Q15 samples
// Top level: configuration registers, the row of stage cells, and the
// result and output registers.
// ----------------------------------------------------------------------------
// One sample is in the cascade at a time. Each stage cell has a single
// 24x24 multiplier that steps through its five products; a filtered
// sample passes through each stage cell in turn, then through the result
// register, and from there moves to the output register once that is free.
// A new sample is taken as soon as the result has moved to the output
// register, even if that result is still stalled. With enable clear the
// sample goes straight to the result register and no stage history changes.
// Coefficients are shared by all stages and may be written only while no
// sample is in flight.
module biquad_cascade_filter #(
  parameter int STAGES = bqc_pkg::NUM_STAGES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out_o
);

  localparam int SAMPLE_W = bqc_pkg::SAMPLE_W;
  localparam int STATE_W  = bqc_pkg::STATE_W;
  localparam int COEF_W   = bqc_pkg::COEF_W;

  logic                       enable_q;
  bqc_pkg::coef_t             coef_q;
  logic                       busy_q;
  logic                       pend_valid_q;
  logic signed [SAMPLE_W-1:0] pend_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_q;

  bqc_pkg::stage_beat_t       chain [STAGES+1];
  logic                       in_accept;
  logic                       out_free;
  logic                       pend_move;
  logic signed [STATE_W-1:0]  last_data;
  logic signed [SAMPLE_W-1:0] last_sat;
  logic                       last_fits;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      coef_q.b0 <= bqc_pkg::COEF_B0_RST;
      coef_q.b1 <= bqc_pkg::COEF_RST;
      coef_q.b2 <= bqc_pkg::COEF_RST;
      coef_q.a1 <= bqc_pkg::COEF_RST;
      coef_q.a2 <= bqc_pkg::COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bqc_pkg::REG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        bqc_pkg::REG_COEF_B0: coef_q.b0 <= cfg_wdata_i[COEF_W-1:0];
        bqc_pkg::REG_COEF_B1: coef_q.b1 <= cfg_wdata_i[COEF_W-1:0];
        bqc_pkg::REG_COEF_B2: coef_q.b2 <= cfg_wdata_i[COEF_W-1:0];
        bqc_pkg::REG_COEF_A1: coef_q.a1 <= cfg_wdata_i[COEF_W-1:0];
        bqc_pkg::REG_COEF_A2: coef_q.a2 <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;

  assign chain[0].valid = in_accept && enable_q;
  assign chain[0].data  = STATE_W'(sample_in_i);

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    bqc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .coef_i (coef_q),
      .in_i   (chain[k]),
      .out_o  (chain[k+1])
    );
  end

  // saturate the last stage to Q15
  assign last_data = chain[STAGES].data;
  assign last_fits = (last_data[STATE_W-1:SAMPLE_W-1] == '0) ||
                     (last_data[STATE_W-1:SAMPLE_W-1] == '1);
  assign last_sat  = last_fits ? last_data[SAMPLE_W-1:0] :
                     (last_data[STATE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                           : {1'b0, {(SAMPLE_W-1){1'b1}}});

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pend_move = pend_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (pend_move) begin
        busy_q <= 1'b0;
      end

      if ((in_accept && !enable_q) || chain[STAGES].valid) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end

      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && !enable_q) begin
      pend_q <= sample_in_i;
    end else if (chain[STAGES].valid) begin
      pend_q <= last_sat;
    end
    if (pend_move) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

// ===== rtl/bqc_cell.sv =====
// ----------------------------------------------------------------------------
// bqc_cell: one direct-form-I biquad stage
// Holds its own two inputs and two outputs of history, runs the five
// products through one multiplier, rounds and saturates to 24 bits and
// hands the result to the next cell.
// ----------------------------------------------------------------------------
module bqc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bqc_pkg::coef_t      coef_i,
  input  bqc_pkg::stage_beat_t in_i,
  output bqc_pkg::stage_beat_t out_o
);

  localparam int STATE_W = bqc_pkg::STATE_W;
  localparam int COEF_W  = bqc_pkg::COEF_W;
  localparam int PROD_W  = bqc_pkg::PROD_W;
  localparam int ACC_W   = bqc_pkg::ACC_W;
  localparam int SHIFT   = bqc_pkg::FRAC_SHIFT;
  localparam int QV_W    = ACC_W - SHIFT;

  localparam logic [2:0] STEP_B0    = 3'd0;
  localparam logic [2:0] STEP_B1    = 3'd1;
  localparam logic [2:0] STEP_B2    = 3'd2;
  localparam logic [2:0] STEP_A1    = 3'd3;
  localparam logic [2:0] STEP_A2    = 3'd4;
  localparam logic [2:0] STEP_DRAIN = 3'd5;
  localparam logic [2:0] STEP_DONE  = 3'd6;

  localparam logic signed [ACC_W-1:0]   RND_HALF = ACC_W'(1) <<< (SHIFT - 1);
  localparam logic signed [STATE_W-1:0] ST_MAX   = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN   = {1'b1, {(STATE_W-1){1'b0}}};

  logic                      busy_q;
  logic [2:0]                step_q;
  logic signed [STATE_W-1:0] s_q, x1_q, x2_q, y1_q, y2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      pv_q, sub_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      out_valid_q;
  logic signed [STATE_W-1:0] out_data_q;

  logic signed [COEF_W-1:0]  op_c;
  logic signed [STATE_W-1:0] op_v;
  logic signed [PROD_W-1:0]  mul;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [QV_W-1:0]    q_val;
  logic signed [STATE_W-1:0] y;
  logic                      q_fits;

  always_comb begin
    case (step_q)
      STEP_B0: begin
        op_c = coef_i.b0;
        op_v = s_q;
      end
      STEP_B1: begin
        op_c = coef_i.b1;
        op_v = x1_q;
      end
      STEP_B2: begin
        op_c = coef_i.b2;
        op_v = x2_q;
      end
      STEP_A1: begin
        op_c = coef_i.a1;
        op_v = y1_q;
      end
      STEP_A2: begin
        op_c = coef_i.a2;
        op_v = y2_q;
      end
      default: begin
        op_c = '0;
        op_v = '0;
      end
    endcase
  end

  assign mul      = PROD_W'(op_c) * PROD_W'(op_v);
  assign prod_ext = ACC_W'(prod_q);

  // round half up, then floor shift to Q.15
  assign rnd_sum = acc_q + RND_HALF;
  assign q_val   = rnd_sum[ACC_W-1:SHIFT];
  assign q_fits  = (q_val[QV_W-1:STATE_W-1] == '0) || (q_val[QV_W-1:STATE_W-1] == '1);
  assign y       = q_fits ? q_val[STATE_W-1:0] : (q_val[QV_W-1] ? ST_MIN : ST_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_B0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
    end else begin
      pv_q        <= busy_q && (step_q <= STEP_A2);
      out_valid_q <= busy_q && (step_q == STEP_DONE);
      if (in_i.valid) begin
        busy_q <= 1'b1;
        step_q <= STEP_B0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == STEP_DONE) begin
          busy_q <= 1'b0;
          // advance history
          x2_q   <= x1_q;
          x1_q   <= s_q;
          y2_q   <= y1_q;
          y1_q   <= y;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul;
    sub_q  <= (step_q == STEP_A1) || (step_q == STEP_A2);
    if (in_i.valid) begin
      s_q   <= in_i.data;
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= sub_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
    if (busy_q && (step_q == STEP_DONE)) begin
      out_data_q <= y;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== rtl/bqc_checker.sv =====
// ----------------------------------------------------------------------------
// bqc_port_checker: port-level checks for the biquad cascade
// Tracks samples in flight from the handshakes and checks occupancy,
// ordering of stall against accept, and the held output beat.
// ----------------------------------------------------------------------------
module bqc_port_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out_o
);

  logic [1:0] outst_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // one sample in the cascade at a time
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // when open for input, only the output register may still hold a result
  a_ready_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (outst_q == 2'd0 || outst_q == 2'd1))
    else $error("input open with a sample still in the cascade");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (outst_q != 2'd0))
    else $error("output beat with no sample accepted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_out_o)))
    else $error("stalled output beat changed");

endmodule

bind biquad_cascade_filter bqc_port_checker u_bqc_checker (.*);
